@@ hdl/fixed_pool_free_list_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// fixed pool allocator assertion macros
// shared property wrappers, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef FIXED_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FPFLA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("fpfla assertion failed");

// next-cycle implication
`define FPFLA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("fpfla assertion failed");

`endif

@@ hdl/fpfla_pkg.sv @@
// ----------------------------------------------------------------------------
// fpfla_pkg
// types and codes shared by the free list allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package fpfla_pkg;

    localparam int FW = 2;   // func and status width
    localparam int XW = 10;  // entry index field width
    localparam int CW = 11;  // count and pool size width

    localparam logic [CW-1:0] POOL_SIZE_RST = 11'd1024;
    localparam logic [CW-1:0] CNT_MAX       = 11'h7FF;

    // operation codes
    localparam logic [FW-1:0] FN_ALLOC  = 2'd0;
    localparam logic [FW-1:0] FN_FREE   = 2'd1;
    localparam logic [FW-1:0] FN_REINIT = 2'd2;

    // result status codes
    localparam logic [FW-1:0] ST_OK    = 2'd0;
    localparam logic [FW-1:0] ST_EMPTY = 2'd1;
    localparam logic [FW-1:0] ST_RANGE = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_POOL_SIZE = 1'b0;

    typedef enum logic [1:0] {
        S_WALK,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic take_in;    // latch the input word
        logic exec;       // commit the operation and load the result
        logic walk_step;  // write one link of the init chain
    } cmd_t;

    typedef struct packed {
        logic out_free;   // result register can be loaded this cycle
        logic op_reinit;  // latched operation is a reinit
        logic walk_last;  // current walk write is the final one
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/fpfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpfla_ctrl
// sequencer: init walk, input acceptance and operation commit
// ----------------------------------------------------------------------------
`default_nettype none

module fpfla_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire fpfla_pkg::stat_t stat,
    output fpfla_pkg::cmd_t     cmd
);
    import fpfla_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WALK;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // head link read finished during the accept cycle
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.op_reinit ? S_WALK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/fpfla_dp.sv @@
// ----------------------------------------------------------------------------
// fpfla_dp
// link memory, list head, counters and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fpfla_dp #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fpfla_pkg::cmd_t             cmd,
    output fpfla_pkg::stat_t                 stat,
    input  wire logic [fpfla_pkg::CW-1:0]    pool_size,
    input  wire logic [fpfla_pkg::FW-1:0]    func,
    input  wire logic [fpfla_pkg::XW-1:0]    entry_index,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [fpfla_pkg::FW-1:0]    status,
    output logic      [fpfla_pkg::XW-1:0]    given_index,
    output logic      [fpfla_pkg::CW-1:0]    free_count,
    output logic      [fpfla_pkg::CW-1:0]    low_water
);
    import fpfla_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW = (IW + 1 > CW) ? IW + 1 : CW;
    localparam logic [SW-1:0] MAX_S = SW'(MAX_ENTRIES);
    localparam logic [CW-1:0] ACT_RST =
        (MAX_ENTRIES < 1024) ? CW'(MAX_ENTRIES) : POOL_SIZE_RST;

    logic [IW-1:0] link_mem [MAX_ENTRIES];
    logic [IW-1:0] rdata_reg;

    logic [IW-1:0] head_reg,  head_next;
    logic [CW-1:0] free_reg,  free_next;
    logic [CW-1:0] least_reg, least_next;
    logic [CW-1:0] act_reg;
    logic [IW-1:0] ptr_reg;
    logic [FW-1:0] func_reg;
    logic [XW-1:0] idx_reg;

    logic          out_valid_reg;
    logic [FW-1:0] status_reg, status_next;
    logic [XW-1:0] given_reg,  given_next;
    logic [CW-1:0] fcnt_reg;
    logic [CW-1:0] lw_reg;

    logic [CW-1:0] size_clamp;
    logic [SW-1:0] ptr_inc;
    logic          free_ok;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_wdata;

    always_comb
    begin
        priority if (pool_size == '0)
        begin
            size_clamp = CW'(1);
        end
        else if (SW'(pool_size) > MAX_S)
        begin
            size_clamp = CW'(MAX_ENTRIES);
        end
        else
        begin
            size_clamp = pool_size;
        end
    end

    assign ptr_inc = SW'(ptr_reg) + SW'(1);
    assign free_ok = ({1'b0, idx_reg} < act_reg);

    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.op_reinit = (func_reg == FN_REINIT);
    assign stat.walk_last = (ptr_inc == SW'(act_reg));

    // commit values for the latched operation
    always_comb
    begin
        head_next   = head_reg;
        free_next   = free_reg;
        least_next  = least_reg;
        status_next = ST_OK;
        given_next  = '0;
        unique case (func_reg)
            FN_ALLOC:
            begin
                if (free_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    given_next = XW'(head_reg);
                    head_next  = rdata_reg;
                    free_next  = free_reg - CW'(1);
                    if (free_next < least_reg)
                    begin
                        least_next = free_next;
                    end
                end
            end
            FN_FREE:
            begin
                if (!free_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    head_next = IW'(idx_reg);
                    if (free_reg != CNT_MAX)
                    begin
                        free_next = free_reg + CW'(1);
                    end
                end
            end
            FN_REINIT:
            begin
                head_next  = '0;
                free_next  = size_clamp;
                least_next = size_clamp;
            end
            default:
            begin
                // unused code leaves the pool alone
            end
        endcase
    end

    assign mem_we    = cmd.walk_step || (cmd.exec && func_reg == FN_FREE && free_ok);
    assign mem_waddr = cmd.walk_step ? ptr_reg : IW'(idx_reg);
    assign mem_wdata = cmd.walk_step ? (stat.walk_last ? '0 : IW'(ptr_inc)) : head_reg;

    // link memory: one write port, registered read at the list head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= link_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            free_reg      <= ACT_RST;
            least_reg     <= ACT_RST;
            act_reg       <= ACT_RST;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg      <= head_next;
                free_reg      <= free_next;
                least_reg     <= least_next;
                out_valid_reg <= 1'b1;
                if (func_reg == FN_REINIT)
                begin
                    act_reg <= size_clamp;
                    ptr_reg <= '0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.walk_step)
            begin
                ptr_reg <= IW'(ptr_inc);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            func_reg <= func;
            idx_reg  <= entry_index;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            given_reg  <= given_next;
            fcnt_reg   <= free_next;
            lw_reg     <= least_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign given_index = given_reg;
    assign free_count  = fcnt_reg;
    assign low_water   = lw_reg;

endmodule

`default_nettype wire

@@ hdl/fixed_pool_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator
// LIFO free list allocator over a pool of fixed-size entries
// ----------------------------------------------------------------------------
// Allocate, free and unknown operations are handled in turn: first the input
// word is accepted, then it is committed once the result register is free; the
// allocate path uses the registered read of the head's link from the link memory.
// Reinit answers the same way and then walks the link memory, one entry per
// cycle, over pool_size entries (clamped to 1..MAX_ENTRIES) while no input is
// taken. After reset the same walk runs over 1024 entries (or MAX_ENTRIES if
// smaller) before the first word is accepted. A pool_size write takes effect
// at the next reinit.
`default_nettype none

module fixed_pool_free_list_allocator #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [fpfla_pkg::FW-1:0]    func,
    input  wire logic [fpfla_pkg::XW-1:0]    entry_index,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [fpfla_pkg::FW-1:0]    status,
    output logic      [fpfla_pkg::XW-1:0]    given_index,
    output logic      [fpfla_pkg::CW-1:0]    free_count,
    output logic      [fpfla_pkg::CW-1:0]    low_water,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import fpfla_pkg::*;

    `include "fixed_pool_free_list_allocator_assert.svh"

    cmd_t          cmd;
    stat_t         stat;
    logic [CW-1:0] pool_size_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            pool_size_reg <= pwdata[CW-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POOL_SIZE) ? {{(32 - CW){1'b0}}, pool_size_reg} : '0;

    fpfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpfla_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .pool_size   (pool_size_reg),
        .func        (func),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .given_index (given_index),
        .free_count  (free_count),
        .low_water   (low_water)
    );

    `FPFLA_ASSERT_IMP(a_lw_below_free, clk, rst_n, out_valid, low_water <= free_count)
    `FPFLA_ASSERT_IMP(a_empty_result, clk, rst_n, out_valid && status == ST_EMPTY,
        free_count == '0 && given_index == '0)
    `FPFLA_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire
